// ===== sv/phi4_metropolis_site_update_defines.svh =====
// assertion macros for the phi4 metropolis site update block
// used by front, back, fifo and top level files
`ifndef PHI4_METROPOLIS_SITE_UPDATE_DEFINES_SVH
`define PHI4_METROPOLIS_SITE_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
`define P4M_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define P4M_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define P4M_ASSERT(label, clk, rst_n, prop, msg)
`define P4M_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== sv/p4m_pkg.sv =====
// shared types, constants and exp helper for the phi4 metropolis block
// no dependencies
`timescale 1ns / 1ps
package p4m_pkg;
  localparam int unsigned DefMaxSites = 4096;
  localparam int unsigned FifoDepth = 2;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_QUAD   = 2'd0,
    CFG_QUART  = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_t;

  localparam logic [16:0] ExpC0 = 17'd65536;
  localparam logic [16:0] ExpC1 = 17'd45426;
  localparam logic [16:0] ExpC2 = 17'd15743;
  localparam logic [16:0] ExpC3 = 17'd3638;
  localparam logic [16:0] ExpC4 = 17'd630;
  localparam logic [16:0] ExpC5 = 17'd87;

  // horner coefficient by step (step 0 uses c4, step 4 uses c0)
  function automatic logic [16:0] exp_coeff(input logic [2:0] k);
    logic [16:0] c;
    case (k)
      3'd0: c = ExpC4;
      3'd1: c = ExpC3;
      3'd2: c = ExpC2;
      3'd3: c = ExpC1;
      3'd4: c = ExpC0;
      default: c = ExpC5;
    endcase
    return c;
  endfunction
endpackage

// ===== sv/phi4_metropolis_site_update.sv =====
// top level of the phi4 metropolis site update block
// depends on p4m_pkg, p4m_front, p4m_fifo, p4m_back
// usage:
//   items transfer on start while busy is low; op selects write, read or
//   metropolis update of site in_site_index
//   each item yields one result, shown for one cycle with out_valid high
//   the receiver cannot stall; results are never held
//   configuration registers are written through cfg_we/cfg_idx/cfg_wdata, without wait;
//   the user must write them only while the block is idle; the block does not enforce it
//   an update takes five serial lattice reads on the single memory read port, then
//   squares, fourth powers, energy terms and, when the exp is needed, a five step
//   horner exp on one multiplier; a write only writes the site, a read only reads it
//   throughput: one item at a time in the back part; the two-entry queue lets
//   the front take a following item while the back still works
//   reset clears control state only; lattice contents are undefined until
//   written and must be loaded before they are read
`timescale 1ns / 1ps
`include "phi4_metropolis_site_update_defines.svh"
module phi4_metropolis_site_update import p4m_pkg::*; #(
  parameter int unsigned MAX_SITES = DefMaxSites
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic [11:0]        in_site_index,
  input  logic signed [15:0] in_write_value,
  input  logic signed [15:0] in_proposal_step,
  input  logic [15:0]        in_uniform_draw,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [23:0]        cfg_wdata,
  output logic               out_valid,
  output logic               out_accepted,
  output logic signed [15:0] out_site_value
);
  localparam int unsigned AW = $clog2(MAX_SITES);
  localparam int unsigned QW = 3 + 5 * AW + 16 + 16 + 16;

  // configuration registers
  logic signed [23:0] quad_r;
  logic [22:0] quart_r;
  logic [6:0] w_r, h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_r <= 24'sd131072;
      quart_r <= 23'd16384;
      w_r <= 7'd64;
      h_r <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_QUAD:   quad_r <= cfg_wdata;
        CFG_QUART:  quart_r <= cfg_wdata[22:0];
        CFG_WIDTH:  w_r <= cfg_wdata[6:0];
        CFG_HEIGHT: h_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  logic take, oob, q_valid, q_full, q_pop;
  logic [1:0] op_cls;
  logic [AW-1:0] a_s, a_xp, a_xm, a_yp, a_ym;
  logic [QW-1:0] q_in, q_out;

  assign busy = q_full;
  assign take = start && !busy;

  p4m_front #(.MAX_SITES(MAX_SITES), .AW(AW)) u_front (
    .clk, .rst_n, .take, .op(in_op), .site_index(in_site_index),
    .cfg_w(w_r), .cfg_h(h_r), .oob, .addr_s(a_s), .addr_xp(a_xp),
    .addr_xm(a_xm), .addr_yp(a_yp), .addr_ym(a_ym), .op_cls
  );

  // classified item packed for the queue
  assign q_in = {op_cls, oob, a_s, a_xp, a_xm, a_yp, a_ym,
                 in_write_value, in_proposal_step, in_uniform_draw};

  p4m_fifo #(.QW(QW)) u_fifo (
    .clk, .rst_n, .push(take), .wdata(q_in), .pop(q_pop),
    .valid(q_valid), .full(q_full), .rdata(q_out)
  );

  p4m_back #(.MAX_SITES(MAX_SITES), .AW(AW), .QW(QW)) u_back (
    .clk, .rst_n, .q_valid, .q_data(q_out), .q_pop,
    .quad_c(quad_r), .quart_c(quart_r),
    .res_valid(out_valid), .res_acc(out_accepted), .res_val(out_site_value)
  );

  `P4M_ASSERT(a_busy, clk, rst_n, busy |-> q_valid, "busy with empty queue")
  `P4M_ASSERT(a_take, clk, rst_n, take |-> !q_full, "take while full")
  `P4M_ASSERT(a_out, clk, rst_n, out_valid |=> !out_valid, "result longer than one cycle")
endmodule

// ===== sv/p4m_front.sv =====
// front end: clamps geometry, classifies items, forms neighbour addresses
// depends on p4m_pkg
`timescale 1ns / 1ps
`include "phi4_metropolis_site_update_defines.svh"
module p4m_front import p4m_pkg::*; #(
  parameter int unsigned MAX_SITES = DefMaxSites,
  parameter int unsigned AW = $clog2(MAX_SITES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [1:0]    op,
  input  logic [11:0]   site_index,
  input  logic [6:0]    cfg_w,
  input  logic [6:0]    cfg_h,
  output logic          oob,
  output logic [AW-1:0] addr_s,
  output logic [AW-1:0] addr_xp,
  output logic [AW-1:0] addr_xm,
  output logic [AW-1:0] addr_yp,
  output logic [AW-1:0] addr_ym,
  output logic [1:0]    op_cls
);
  localparam int unsigned SW = AW + 2;
  logic [6:0] w_c, h_c;
  logic [13:0] prod;
  logic [SW-1:0] size, s_ext, wm, t;

  always_comb begin
    w_c = (cfg_w < 7'd2) ? 7'd2 : ((cfg_w > 7'd64) ? 7'd64 : cfg_w);
    h_c = (cfg_h < 7'd2) ? 7'd2 : ((cfg_h > 7'd64) ? 7'd64 : cfg_h);
    prod = 14'(w_c * h_c);
    size = (32'(prod) > 32'(MAX_SITES)) ? SW'(MAX_SITES) : SW'(prod);
    wm = (SW'(w_c) >= size) ? SW'(w_c) - size : SW'(w_c);
    s_ext = SW'(site_index);
    oob = (32'(site_index) >= 32'(size));
    op_cls = (op == OP_SPARE) ? OP_READ : op;
    addr_s = s_ext[AW-1:0];
    t = s_ext + SW'(1);
    addr_xp = (t >= size) ? AW'(t - size) : AW'(t);
    addr_xm = (s_ext == '0) ? AW'(size - SW'(1)) : AW'(s_ext - SW'(1));
    t = s_ext + wm;
    addr_yp = (t >= size) ? AW'(t - size) : AW'(t);
    addr_ym = (s_ext >= wm) ? AW'(s_ext - wm) : AW'(s_ext + size - wm);
  end

  `P4M_ASSERT(a_cls, clk, rst_n, take |-> op_cls != OP_SPARE, "spare op not folded")
  `P4M_ASSERT(a_xp, clk, rst_n, (take && !oob) |-> addr_xp != addr_s || AW == 0, "next x equals site")
  `P4M_ASSERT(a_ym, clk, rst_n, (take && !oob) |-> 32'(addr_ym) < 32'(MAX_SITES), "prev y outside")
endmodule

// ===== sv/p4m_back.sv =====
// back end: lattice memory, energy change, exp approximation, acceptance
// depends on p4m_pkg
`timescale 1ns / 1ps
`include "phi4_metropolis_site_update_defines.svh"
module p4m_back import p4m_pkg::*; #(
  parameter int unsigned MAX_SITES = DefMaxSites,
  parameter int unsigned AW = $clog2(MAX_SITES),
  parameter int unsigned QW = 3 + 5 * AW + 16 + 16 + 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  logic [QW-1:0]      q_data,
  output logic               q_pop,
  input  logic signed [23:0] quad_c,
  input  logic [22:0]        quart_c,
  output logic               res_valid,
  output logic               res_acc,
  output logic signed [15:0] res_val
);
  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001, S_RD0  = 12'b000000000010,
    S_RD1  = 12'b000000000100, S_RD2  = 12'b000000001000,
    S_RD3  = 12'b000000010000, S_RD4  = 12'b000000100000,
    S_SQ   = 12'b000001000000, S_P4   = 12'b000010000000,
    S_TRM  = 12'b000100000000, S_DLT  = 12'b001000000000,
    S_EXP  = 12'b010000000000, S_DONE = 12'b100000000000
  } st_t;

  logic [15:0] mem [MAX_SITES];
  logic [15:0] rdata_r;
  logic [AW-1:0] raddr;
  logic        we;
  logic [AW-1:0] waddr;
  logic [15:0] wdata;

  st_t st_r, st_nxt;
  logic [1:0] op;
  logic oob;
  logic [AW-1:0] a_s, a_xp, a_xm, a_yp, a_ym;
  logic signed [15:0] wv, stp;
  logic [15:0] u;

  logic [1:0] op_r;
  logic oob_r;
  logic [AW-1:0] a_s_r, a_xp_r, a_xm_r, a_yp_r, a_ym_r;
  logic signed [15:0] wv_r, stp_r;
  logic [15:0] u_r;
  logic signed [15:0] old_r, nw_r;
  logic signed [17:0] nb_r;
  logic [31:0] n2_r, o2_r;
  logic [31:0] n4_r, o4_r;
  logic signed [47:0] t1_r, t2_r, t3_r;
  logic [47:0] tt_r;
  logic [16:0] p_r;
  logic [2:0] k_r;
  logic acc_r, res_valid_r;
  logic signed [15:0] res_val_r;

  assign {op, oob, a_s, a_xp, a_xm, a_yp, a_ym, wv, stp, u} = q_data;

  // site read issued in rd0, neighbours in rd1 to rd4
  always_comb begin
    case (st_r)
      S_RD1: raddr = a_xp_r;
      S_RD2: raddr = a_xm_r;
      S_RD3: raddr = a_yp_r;
      S_RD4: raddr = a_ym_r;
      default: raddr = a_s_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  logic signed [16:0] sum17;
  logic signed [15:0] nw_sat;
  logic signed [16:0] diff;
  logic signed [32:0] d2;
  logic signed [33:0] d4;
  logic signed [49:0] dsum;
  logic [16:0] pmul;
  logic [33:0] pprod;

  always_comb begin
    sum17 = 17'(old_r) + 17'(stp_r);
    nw_sat = (sum17 > 17'sd32767) ? 16'sh7fff :
             (sum17 < -17'sd32768) ? 16'sh8000 : sum17[15:0];
    diff = 17'(old_r) - 17'(nw_r);
    d2 = $signed({1'b0, n2_r}) - $signed({1'b0, o2_r});
    d4 = $signed({2'b0, n4_r}) - $signed({2'b0, o4_r});
    dsum = 50'(t1_r) + 50'(t2_r) + 50'(t3_r);
    pprod = 34'(p_r) * 34'(tt_r[15:0]);
    pmul = exp_coeff(k_r) - 17'(pprod >> 16);
  end

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    we = 1'b0;
    waddr = a_s_r;
    wdata = wv_r;
    case (st_r)
      S_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        st_nxt = S_RD0;
      end
      S_RD0: begin
        if (oob_r || op_r == OP_READ) st_nxt = S_RD1;
        else if (op_r == OP_WRITE) begin
          we = 1'b1;
          st_nxt = S_DONE;
        end else st_nxt = S_RD1;
      end
      S_RD1: st_nxt = (op_r == OP_UPDATE && !oob_r) ? S_RD2 : S_DONE;
      S_RD2: st_nxt = S_RD3;
      S_RD3: st_nxt = S_RD4;
      S_RD4: st_nxt = S_SQ;
      S_SQ:  st_nxt = S_P4;
      S_P4:  st_nxt = S_TRM;
      S_TRM: st_nxt = S_DLT;
      S_DLT: st_nxt = (dsum <= 0) ? S_DONE : S_EXP;
      S_EXP: if (k_r == 3'd4) st_nxt = S_DONE;
      S_DONE: begin
        if (op_r == OP_UPDATE && !oob_r && acc_r) begin
          we = 1'b1;
          wdata = nw_r;
        end
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      res_valid_r <= (st_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        {op_r, oob_r, a_s_r, a_xp_r, a_xm_r, a_yp_r, a_ym_r} <=
          {op, oob, a_s, a_xp, a_xm, a_yp, a_ym};
        wv_r <= wv; stp_r <= stp; u_r <= u; acc_r <= 1'b0;
      end
      S_RD1: old_r <= rdata_r;
      S_RD2: nb_r <= 18'(signed'(rdata_r));
      S_RD3: nb_r <= nb_r + 18'(signed'(rdata_r));
      S_RD4: begin
        nb_r <= nb_r + 18'(signed'(rdata_r));
        nw_r <= nw_sat;
      end
      S_SQ: begin
        nb_r <= nb_r + 18'(signed'(rdata_r));
        n2_r <= 32'(nw_r * nw_r);
        o2_r <= 32'(old_r * old_r);
      end
      S_P4: begin
        n4_r <= 32'((64'(n2_r) * 64'(n2_r)) >> 32);
        o4_r <= 32'((64'(o2_r) * 64'(o2_r)) >> 32);
        t1_r <= 48'((35'(diff) * 35'(nb_r)) >>> 8);
      end
      S_TRM: begin
        t2_r <= 48'((58'(quad_c) * 58'(d2)) >>> 24);
        t3_r <= 48'((58'($signed({1'b0, quart_c})) * 58'(d4)) >>> 16);
      end
      S_DLT: begin
        tt_r <= 48'((48'(dsum > 50'sd2147483647 ? 32'h7fffffff : dsum[31:0])
                 * 48'd94548) >> 16);
        acc_r <= (dsum <= 0);
        p_r <= ExpC5;
        k_r <= 3'd0;
      end
      S_EXP: begin
        p_r <= pmul;
        k_r <= k_r + 3'd1;
        if (k_r == 3'd4)
          acc_r <= (tt_r[47:16] < 32'd17) &&
                   ({16'b0, u_r} < (32'(pmul) >> tt_r[20:16]));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == S_DONE) begin
      if (oob_r) begin
        res_acc <= 1'b0;
        res_val_r <= '0;
      end else if (op_r == OP_WRITE) begin
        res_acc <= 1'b0;
        res_val_r <= wv_r;
      end else if (op_r == OP_UPDATE) begin
        res_acc <= acc_r;
        res_val_r <= acc_r ? nw_r : old_r;
      end else begin
        res_acc <= 1'b0;
        res_val_r <= old_r;
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res_val = res_val_r;

  `P4M_ASSERT(a_pop, clk, rst_n, q_pop |-> q_valid, "pop from empty queue")
  `P4M_ASSERT(a_res, clk, rst_n, res_valid |-> $past(st_r) == S_DONE, "stray result")
  `P4M_ASSERT(a_exp, clk, rst_n, (st_r == S_EXP) |-> k_r <= 3'd4, "exp step overrun")
endmodule

// ===== sv/p4m_fifo.sv =====
// two-entry queue between front and back parts
// depends on p4m_pkg
`timescale 1ns / 1ps
`include "phi4_metropolis_site_update_defines.svh"
module p4m_fifo import p4m_pkg::*; #(
  parameter int unsigned QW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [QW-1:0] wdata,
  input  logic          pop,
  output logic          valid,
  output logic          full,
  output logic [QW-1:0] rdata
);
  logic [QW-1:0] ent_r [FifoDepth];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
  always_ff @(posedge clk) if (push) ent_r[wp_r] <= wdata;

  assign valid = (cnt_r != 2'd0);
  assign full = (cnt_r == 2'd2);
  assign rdata = ent_r[rp_r];

  `P4M_ASSERT(a_ovf, clk, rst_n, push |-> !full, "queue overflow")
  `P4M_ASSERT(a_cnt, clk, rst_n, cnt_r <= 2'd2, "queue count broken")
  `P4M_ASSERT(a_udf, clk, rst_n, pop |-> valid, "queue underflow")
endmodule
